### rtl/core/vn_pkg.sv
// vn_pkg: shared types and constants of the vector normalize core
// no dependencies

package vn_pkg;

	localparam int IN_FRAC_BITS_DEF = 16;

	localparam int APB_AW = 3;
	localparam logic [APB_AW-1:0] ADDR_TOL = 3'd0;

	typedef enum logic [1:0] {
		NC_DIV  = 2'd0,
		NC_PASS = 2'd1,
		NC_ZERO = 2'd2
	} norm_case_t;

	typedef struct packed {
		logic [2:0][31:0] c;
		logic [2:0][31:0] m;
		norm_case_t       nc;
		logic [4:0]       k;
	} vn_ctx_t;

endpackage

### rtl/core/vn_if.sv
// vn_in_if / vn_out_if: valid-ready channels of the vector normalize core
// no dependencies

interface vn_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] vec_x;
	logic [31:0] vec_y;
	logic [31:0] vec_z;

	modport source (output valid, vec_x, vec_y, vec_z, input ready);
	modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface vn_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] unit_x;
	logic [31:0] unit_y;
	logic [31:0] unit_z;
	logic [1:0]  norm_case;

	modport source (output valid, unit_x, unit_y, unit_z, norm_case, input ready);
	modport sink   (input valid, unit_x, unit_y, unit_z, norm_case, output ready);
endinterface

### rtl/core/vector3_normalize_top.sv
// Normalizes a signed fixed-point 3D vector to Q2.30; one beat in, one beat out.
// The pipeline takes a new vector every cycle; it stalls as a whole only while the
// output beat waits for ready. It is made up of the input register, squaring, sum, tests,
// a five-stage leading-zero shift, the 32 square-root stages, the dividend setup, the 32
// divider stages (one result bit per stage each) and the output register.
// depends on vn_pkg, vn_in_if, vn_out_if

module vector3_normalize_top #(
	parameter int IN_FRAC_BITS = vn_pkg::IN_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [vn_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	vn_in_if.sink                     in_vec,
	vn_out_if.source                  out_vec
);

	localparam int E      = 2 * IN_FRAC_BITS;
	localparam int TSH_UP = (E >= 32) ? E - 32 : 0;
	localparam int TSH_DN = (E >= 32) ? 0 : 32 - E;
	localparam int PSH    = 30 - IN_FRAC_BITS;
	localparam int NS     = 5;
	localparam int QS     = 32;
	localparam int DS     = 32;
	localparam logic [63:0] ONE = 64'd1 << E;

	logic [15:0] tol_q;
	logic        adv;
	logic        out_valid_q;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr == vn_pkg::ADDR_TOL) ? {16'd0, tol_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (psel && penable && pwrite && paddr == vn_pkg::ADDR_TOL) begin
			tol_q <= pwdata[15:0];
		end
	end

	logic [63:0] tol_w;
	assign tol_w = ({48'd0, tol_q} << TSH_UP) >> TSH_DN;

	assign adv          = !out_valid_q || out_vec.ready;
	assign in_vec.ready = adv;

	// input, square, sum, tests
	logic             v_s0, v_s1, v_s2, v_s3;
	logic [2:0][31:0] c_s0, c_s1, c_s2, c_s3;
	logic [2:0][31:0] m_s1, m_s2, m_s3;
	logic [2:0][63:0] sq_s1;
	logic [63:0]      s_s2, s_s3;
	vn_pkg::norm_case_t nc_s3;
	logic [2:0][31:0] m0;
	logic [63:0]      dev2;
	vn_pkg::norm_case_t nc2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m0[i] = c_s0[i][31] ? 32'(-c_s0[i]) : c_s0[i];
		end
		dev2 = (s_s2 >= ONE) ? s_s2 - ONE : ONE - s_s2;
		if (dev2 <= tol_w) begin
			nc2 = vn_pkg::NC_PASS;
		end else if (s_s2 <= tol_w) begin
			nc2 = vn_pkg::NC_ZERO;
		end else begin
			nc2 = vn_pkg::NC_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s0 <= in_vec.valid;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s0 <= {in_vec.vec_z, in_vec.vec_y, in_vec.vec_x};
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= {32'd0, m0[i]} * {32'd0, m0[i]};
			end
			c_s1  <= c_s0;
			m_s1  <= m0;
			s_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			c_s2  <= c_s1;
			m_s2  <= m_s1;
			s_s3  <= s_s2;
			c_s3  <= c_s2;
			m_s3  <= m_s2;
			nc_s3 <= nc2;
		end
	end

	// leading-zero normalization, two bits per k
	logic            v_n   [0:NS];
	vn_pkg::vn_ctx_t ctx_n [0:NS];
	logic [63:0]     sn_n  [0:NS];

	assign v_n[0]   = v_s3;
	assign sn_n[0]  = s_s3;
	assign ctx_n[0] = '{c: c_s3, m: m_s3, nc: nc_s3, k: 5'd0};

	for (genvar j = 0; j < NS; j++) begin : g_norm
		localparam int SH = 16 >> j;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_n[j+1] <= 1'b0;
			end else if (adv) begin
				v_n[j+1] <= v_n[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (sn_n[j][63 -: 2*SH] == '0) begin
					sn_n[j+1]  <= sn_n[j] << (2*SH);
					ctx_n[j+1] <= '{c: ctx_n[j].c, m: ctx_n[j].m, nc: ctx_n[j].nc,
						k: ctx_n[j].k + 5'(SH)};
				end else begin
					sn_n[j+1]  <= sn_n[j];
					ctx_n[j+1] <= ctx_n[j];
				end
			end
		end
	end

	// square root, one root bit per stage
	logic            v_q    [0:QS];
	vn_pkg::vn_ctx_t ctx_q  [0:QS];
	logic [63:0]     rad_q  [0:QS];
	logic [33:0]     rem_q  [0:QS];
	logic [31:0]     root_q [0:QS];

	assign v_q[0]    = v_n[NS];
	assign ctx_q[0]  = ctx_n[NS];
	assign rad_q[0]  = sn_n[NS];
	assign rem_q[0]  = '0;
	assign root_q[0] = '0;

	for (genvar j = 0; j < QS; j++) begin : g_sqrt
		logic [35:0] remx;
		logic [35:0] trial;
		logic        ge;
		assign remx  = {rem_q[j], rad_q[j][63:62]};
		assign trial = {2'd0, root_q[j], 2'b01};
		assign ge    = remx >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j+1] <= 1'b0;
			end else if (adv) begin
				v_q[j+1] <= v_q[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ctx_q[j+1]  <= ctx_q[j];
				rad_q[j+1]  <= rad_q[j] << 2;
				rem_q[j+1]  <= ge ? 34'(remx - trial) : remx[33:0];
				root_q[j+1] <= {root_q[j][30:0], ge};
			end
		end
	end

	// dividend setup with half-divisor rounding
	logic            v_p;
	vn_pkg::vn_ctx_t ctx_p;
	logic [31:0]     r_p;
	logic [2:0][62:0] num_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (adv) begin
			v_p <= v_q[QS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_p <= ctx_q[QS];
			r_p   <= root_q[QS];
			for (int i = 0; i < 3; i++) begin
				num_p[i] <= ((63'(ctx_q[QS].m[i]) << ctx_q[QS].k) << 30)
					+ 63'(root_q[QS] >> 1);
			end
		end
	end

	// restoring divide, one quotient bit per stage per lane
	logic            v_d   [0:DS];
	vn_pkg::vn_ctx_t ctx_d [0:DS];
	logic [31:0]     r_d   [0:DS];
	logic [31:0]     drem  [0:2][0:DS];
	logic [31:0]     dlo   [0:2][0:DS];
	logic [31:0]     dq    [0:2][0:DS];

	assign v_d[0]   = v_p;
	assign ctx_d[0] = ctx_p;
	assign r_d[0]   = r_p;

	for (genvar l = 0; l < 3; l++) begin : g_lane_in
		assign drem[l][0] = {1'b0, num_p[l][62:32]};
		assign dlo[l][0]  = num_p[l][31:0];
		assign dq[l][0]   = '0;
	end

	for (genvar j = 0; j < DS; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[j+1] <= 1'b0;
			end else if (adv) begin
				v_d[j+1] <= v_d[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ctx_d[j+1] <= ctx_d[j];
				r_d[j+1]   <= r_d[j];
			end
		end
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [32:0] remx;
			logic        ge;
			assign remx = {drem[l][j], dlo[l][j][31]};
			assign ge   = remx >= {1'b0, r_d[j]};
			always_ff @(posedge clk) begin
				if (adv) begin
					drem[l][j+1] <= ge ? 32'(remx - {1'b0, r_d[j]}) : remx[31:0];
					dlo[l][j+1]  <= dlo[l][j] << 1;
					dq[l][j+1]   <= {dq[l][j][30:0], ge};
				end
			end
		end
	end

	// sign, saturation and case select
	logic [2:0][31:0] res;
	vn_pkg::vn_ctx_t  cf;

	assign cf = ctx_d[DS];

	always_comb begin
		logic signed [63:0] pv;
		logic [31:0]        q;
		for (int i = 0; i < 3; i++) begin
			pv = $signed({{32{cf.c[i][31]}}, cf.c[i]}) <<< PSH;
			q  = dq[i][DS];
			case (cf.nc)
				vn_pkg::NC_PASS: begin
					if (pv > 64'sh7fff_ffff) begin
						res[i] = 32'h7fff_ffff;
					end else if (pv < -64'sh8000_0000) begin
						res[i] = 32'h8000_0000;
					end else begin
						res[i] = pv[31:0];
					end
				end
				vn_pkg::NC_ZERO: res[i] = '0;
				default: begin
					if (!cf.c[i][31]) begin
						res[i] = (q > 32'h7fff_ffff) ? 32'h7fff_ffff : q;
					end else begin
						res[i] = (q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_d[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_vec.unit_x    <= res[0];
			out_vec.unit_y    <= res[1];
			out_vec.unit_z    <= res[2];
			out_vec.norm_case <= cf.nc;
		end
	end

	assign out_vec.valid = out_valid_q;

endmodule

### rtl/core/vn_checker.sv
// vn_props: port-level assertions for the vector normalize core, with its bind
// depends on vn_pkg and vector3_normalize_top

module vn_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] unit_x,
	input logic [31:0] unit_y,
	input logic [31:0] unit_z,
	input logic [1:0]  norm_case,
	input logic        pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(unit_x) && $stable(unit_y)
			&& $stable(unit_z) && $stable(norm_case))
		else $error("output beat changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> norm_case == vn_pkg::NC_DIV || norm_case == vn_pkg::NC_PASS
			|| norm_case == vn_pkg::NC_ZERO)
		else $error("undefined case code");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && norm_case == vn_pkg::NC_ZERO |-> unit_x == '0 && unit_y == '0
			&& unit_z == '0)
		else $error("zero case with nonzero components");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("config port not ready");

endmodule

bind vector3_normalize_top vn_props u_vn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_vec.ready),
	.out_valid (out_vec.valid),
	.out_ready (out_vec.ready),
	.unit_x    (out_vec.unit_x),
	.unit_y    (out_vec.unit_y),
	.unit_z    (out_vec.unit_z),
	.norm_case (out_vec.norm_case),
	.pready    (pready)
);
